### sv/indent_dedent_tracker_core_assert.svh
// Assertion macros shared by the indentation tracker RTL.
`ifndef INDENT_DEDENT_TRACKER_CORE_ASSERT_SVH
`define INDENT_DEDENT_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IDT_ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("indent tracker check failed");

// Next-cycle implication, checked outside reset.
`define IDT_ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("indent tracker check failed");

`endif

### sv/idt_pkg.sv
// Types and constants shared by the indentation tracker modules.
`default_nettype none

package idt_pkg;

	localparam int LEVEL_BITS = 12;
	localparam int IN_COL_BITS = 12;

	typedef enum logic [1:0] {
		KIND_INDENT = 2'd0,
		KIND_DEDENT = 2'd1,
		KIND_ERROR  = 2'd2
	} token_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DEPTH    = 2'd1,
		ERR_MISMATCH = 2'd2
	} error_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_POP_WR,
		ST_ERR_OUT
	} state_t;

	typedef struct packed {
		logic                  last;
		logic [LEVEL_BITS-1:0] level;
		error_code_t           code;
		token_kind_t           kind;
	} result_t;

endpackage

`default_nettype wire

### sv/idt_stack_ram.sv
// Column stack storage: one write port, one registered read port.
`default_nettype none

module idt_stack_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read, so a stalled consumer sees it stable.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### sv/idt_ctrl.sv
// Indentation tracker sequencer: compares, pushes, pops and forms results.
`default_nettype none

`include "indent_dedent_tracker_core_assert.svh"

module idt_ctrl #(
	parameter int STACK_DEPTH = 64,
	parameter int COLUMN_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [idt_pkg::IN_COL_BITS-1:0] in_col,
	input  wire logic                          in_skip,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output idt_pkg::result_t                   out_res,
	output logic                               mem_wr_en,
	output logic [$clog2(STACK_DEPTH)-1:0]     mem_wr_addr,
	output logic [COLUMN_BITS-1:0]             mem_wr_data,
	output logic                               mem_rd_en,
	output logic [$clog2(STACK_DEPTH)-1:0]     mem_rd_addr,
	input  wire logic [COLUMN_BITS-1:0]        mem_rd_data
);

	import idt_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t                 state_q, state_d;
	logic [CW-1:0]          count_q, count_d;
	logic [COLUMN_BITS-1:0] top_q, top_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;
	logic                   failed_q, failed_d;
	logic                   out_valid_q, out_valid_d;
	result_t                out_res_q, out_res_d;

	logic                   out_free;
	logic [COLUMN_BITS-1:0] col_in;
	logic [CW-1:0]          count_m2;
	logic [COLUMN_BITS-1:0] below_top;

	assign col_in   = COLUMN_BITS'(in_col);
	assign count_m2 = count_q - CW'(2);
	assign out_free = !out_valid_q || out_ready;
	// Entry zero is never written; it always stands for column zero.
	assign below_top = (count_q == CW'(2)) ? '0 : mem_rd_data;

	assign mem_wr_addr = count_q[AW-1:0];
	assign mem_wr_data = col_in;
	assign mem_rd_addr = count_m2[AW-1:0];

	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		top_d       = top_q;
		col_d       = col_q;
		failed_d    = failed_q;
		out_valid_d = out_valid_q && !out_ready;
		out_res_d   = out_res_q;
		mem_wr_en   = 1'b0;
		mem_rd_en   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					if (failed_q) begin
						out_valid_d = 1'b1;
						out_res_d   = '{last: 1'b1, level: LEVEL_BITS'(top_q),
							code: ERR_NONE, kind: KIND_ERROR};
					end else if (!in_skip) begin
						if (col_in > top_q) begin
							out_valid_d = 1'b1;
							if (count_q == CW'(STACK_DEPTH)) begin
								failed_d  = 1'b1;
								out_res_d = '{last: 1'b1, level: LEVEL_BITS'(top_q),
									code: ERR_DEPTH, kind: KIND_ERROR};
							end else begin
								mem_wr_en = 1'b1;
								count_d   = count_q + CW'(1);
								top_d     = col_in;
								out_res_d = '{last: 1'b1, level: LEVEL_BITS'(col_in),
									code: ERR_NONE, kind: KIND_INDENT};
							end
						end else if (col_in < top_q) begin
							col_d   = col_in;
							state_d = ST_POP_RD;
						end
					end
				end
			end
			ST_POP_RD: begin
				mem_rd_en = 1'b1;
				state_d   = ST_POP_WR;
			end
			ST_POP_WR: begin
				if (out_free) begin
					count_d     = count_q - CW'(1);
					top_d       = below_top;
					out_valid_d = 1'b1;
					out_res_d   = '{last: 1'b0, level: LEVEL_BITS'(below_top),
						code: ERR_NONE, kind: KIND_DEDENT};
					if (below_top > col_q) begin
						state_d = ST_POP_RD;
					end else if (below_top == col_q) begin
						out_res_d.last = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						state_d = ST_ERR_OUT;
					end
				end
			end
			ST_ERR_OUT: begin
				if (out_free) begin
					failed_d    = 1'b1;
					out_valid_d = 1'b1;
					out_res_d   = '{last: 1'b1, level: LEVEL_BITS'(top_q),
						code: ERR_MISMATCH, kind: KIND_ERROR};
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= CW'(1);
			top_q       <= '0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			top_q       <= top_d;
			failed_q    <= failed_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		col_q     <= col_d;
		out_res_q <= out_res_d;
	end

	`IDT_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1,
		(count_q != '0) && (count_q <= CW'(STACK_DEPTH)))
	`IDT_ASSERT_IMP(a_pop_only_deeper, clk, arst_n, state_q == ST_POP_RD,
		(top_q > col_q) && (count_q > CW'(1)))
	`IDT_ASSERT_NXT(a_failed_sticks, clk, arst_n, failed_q, failed_q)
	`IDT_ASSERT_NXT(a_halted_answers_error, clk, arst_n,
		in_valid && in_ready && failed_q,
		out_valid_q && (out_res_q.kind == KIND_ERROR) && out_res_q.last)

endmodule

`default_nettype wire

### sv/indent_dedent_tracker_core.sv
// Top level of the offside-rule indentation tracker with stream ports.
`default_nettype none

// Offside-rule indentation tracker. Each input item is one source line: the
// count of leading spaces in s_tdata and a skip flag in s_tuser for blank,
// comment or end-of-text lines. The block keeps a stack of open indentation
// columns (bottom column zero) in a synchronous memory and emits indent,
// dedent and error results on the master side, one result per output item,
// with m_tlast set on the final result caused by an input item. After any
// error every later input item is answered by a single error result until
// reset. A push, a depth error or a halted answer is registered as its line
// is accepted; skipped and equal lines issue no result. Each dedent pops one
// column: ST_POP_RD reads the column below from the stack memory and
// ST_POP_WR, waiting for a free output register, takes it as the new top. A
// trailing mismatch error comes from ST_ERR_OUT. A new input item is
// accepted only when the previous one has issued all its results and the
// output register is empty or hands its item over in that same cycle, so a
// stalled master side also holds off the slave side. Reset needs no
// clearing pass: stack entry zero is never stored and always reads as zero.
module indent_dedent_tracker_core #(
	parameter int STACK_DEPTH = 64,
	parameter int COLUMN_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [11:0] indent_columns, [15:12] zero
	input  wire logic [0:0]  s_tuser,  // [0] skip_line
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [1:0] error_code, [13:2] level_after, [15:14] zero
	output logic [1:0]       m_tuser,  // [1:0] token_kind
	output logic             m_tlast
);

	import idt_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);

	result_t                res;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [COLUMN_BITS-1:0] wr_data;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [COLUMN_BITS-1:0] rd_data;

	idt_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.COLUMN_BITS (COLUMN_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_col      (s_tdata[IN_COL_BITS-1:0]),
		.in_skip     (s_tuser[0]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (res),
		.mem_wr_en   (wr_en),
		.mem_wr_addr (wr_addr),
		.mem_wr_data (wr_data),
		.mem_rd_en   (rd_en),
		.mem_rd_addr (rd_addr),
		.mem_rd_data (rd_data)
	);

	idt_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (COLUMN_BITS)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Pack the result: the kind rides in tuser, the code and level in tdata.
	assign m_tdata = {2'b00, res.level, res.code};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the offside-rule indentation tracker with stream ports.
module tb;
	import idt_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int COLUMN_MAX = 4095;
	localparam int RANDOM_LINES = 36;
	localparam int SCRIPT_ROWS = 20;
	localparam int DRAIN_CYCLES = 20;

	// One line of stimulus. When typed is set, the expected outcome is written in the row
	// itself: either nothing, or a single indent/dedent token at the given level.
	typedef struct packed {
		logic [11:0] col;
		logic        skip;
		logic        typed;
		logic        one_token;
		token_kind_t kind;
		logic [11:0] level;
	} line_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [11:0] indent_columns, [15:12] zero
	logic [0:0]  s_tuser = '0;  // [0] skip_line
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // [1:0] error_code, [13:2] level_after, [15:14] zero
	logic [1:0]  m_tuser;       // [1:0] token_kind
	logic        m_tlast;

	indent_dedent_tracker_core #(
		.STACK_DEPTH(STACK_DEPTH),
		.COLUMN_BITS(12)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Shadow copy of the indentation stack, kept in step with every accepted line.
	logic [11:0] open_cols [0:STACK_DEPTH-1];
	int unsigned open_depth = 1;
	bit          halted = 1'b0;
	result_t     pending_tokens [$];
	int          errors = 0;
	bit          idle_en = 1'b1;
	int          stall_left = 0;
	line_row_t   script [0:SCRIPT_ROWS-1];

	function automatic logic [11:0] top_col();
		return open_cols[open_depth-1];
	endfunction

	function automatic result_t make_token(token_kind_t kind, error_code_t code);
		result_t tok;
		tok.kind = kind;
		tok.code = code;
		tok.level = top_col();
		tok.last = 1'b0;
		return tok;
	endfunction

	function automatic line_row_t plain_row(logic [11:0] col, logic skip);
		line_row_t row;
		row = '0;
		row.col = col;
		row.skip = skip;
		return row;
	endfunction

	// Works out the tokens one line causes, updates the shadow stack and queues the tokens.
	// The last token of the batch carries the end-of-line mark.
	task automatic predict_line(input logic [11:0] col, input logic skip);
		result_t batch [0:STACK_DEPTH-1];
		int n;
		n = 0;
		if (halted) begin
			// A halted tracker answers every line, skipped or not, with one error token.
			batch[n] = make_token(KIND_ERROR, ERR_NONE);
			n++;
		end else if (!skip && col > top_col()) begin
			if (open_depth == STACK_DEPTH) begin
				halted = 1'b1;
				batch[n] = make_token(KIND_ERROR, ERR_DEPTH);
				n++;
			end else begin
				open_cols[open_depth] = col;
				open_depth++;
				batch[n] = make_token(KIND_INDENT, ERR_NONE);
				n++;
			end
		end else if (!skip && col < top_col()) begin
			while (open_depth > 1 && top_col() > col) begin
				open_depth--;
				batch[n] = make_token(KIND_DEDENT, ERR_NONE);
				n++;
			end
			// The dedent must land exactly on an open column.
			if (top_col() != col) begin
				halted = 1'b1;
				batch[n] = make_token(KIND_ERROR, ERR_MISMATCH);
				n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				batch[i].last = 1'b1;
			pending_tokens.push_back(batch[i]);
		end
	endtask

	// Offers one line on the slave side, waits for the handshake and records what it should
	// cause. An optional idle burst precedes the offer.
	task automatic send_line(input line_row_t row);
		int      queued_count;
		result_t tok;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, row.col};
		s_tuser <= row.skip;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		queued_count = pending_tokens.size();
		predict_line(row.col, row.skip);
		if (row.typed) begin
			// The row states its own outcome; the shadow stack still moves on.
			while (pending_tokens.size() > queued_count)
				tok = pending_tokens.pop_back();
			if (row.one_token) begin
				tok.kind = row.kind;
				tok.code = ERR_NONE;
				tok.level = row.level;
				tok.last = 1'b1;
				pending_tokens.push_back(tok);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the tracker hangs.
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Master-side back-pressure: random stalls while idling is enabled.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Each accepted output item is compared against the oldest queued token.
	always @(posedge clk) begin : check_tokens
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tokens.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected token: kind %0d code %0d level %0d last %0d",
						m_tuser, m_tdata[1:0], m_tdata[13:2], m_tlast);
			end else begin
				want = pending_tokens.pop_front();
				if (m_tuser !== want.kind || m_tdata[1:0] !== want.code ||
						m_tdata[13:2] !== want.level || m_tlast !== want.last) begin
					errors++;
					if (errors <= 10)
						$display({"token mismatch: want kind %0d code %0d level %0d ",
							"last %0d, got kind %0d code %0d level %0d last %0d"},
							want.kind, want.code, want.level, want.last,
							m_tuser, m_tdata[1:0], m_tdata[13:2], m_tlast);
				end
			end
		end
	end

	initial begin : stimulus
		logic [11:0] col;
		int          pick;
		int          idx;
		logic        skip;
		open_cols[0] = '0;

		// Directed lines from reset. No line here causes an error, since an error halts the
		// tracker for the rest of the run.
		script[0]  = {12'd0,    1'b0, 1'b1, 1'b0, KIND_INDENT, 12'd0};    // equal to bottom
		script[1]  = {12'd4095, 1'b1, 1'b1, 1'b0, KIND_INDENT, 12'd0};    // skipped, max column
		script[2]  = {12'd1,    1'b0, 1'b1, 1'b1, KIND_INDENT, 12'd1};
		script[3]  = {12'd4095, 1'b0, 1'b1, 1'b1, KIND_INDENT, 12'd4095};
		script[4]  = {12'd4095, 1'b0, 1'b1, 1'b0, KIND_INDENT, 12'd0};    // equal at max
		script[5]  = {12'd0,    1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};    // two dedents
		script[6]  = {12'd4,    1'b0, 1'b1, 1'b1, KIND_INDENT, 12'd4};
		script[7]  = {12'd8,    1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};
		script[8]  = {12'd12,   1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};
		script[9]  = {12'd2,    1'b1, 1'b1, 1'b0, KIND_INDENT, 12'd0};    // skipped, shallower
		script[10] = {12'd8,    1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};    // one dedent
		script[11] = {12'd8,    1'b0, 1'b1, 1'b0, KIND_INDENT, 12'd0};    // equal
		script[12] = {12'd16,   1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};
		script[13] = {12'd0,    1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};    // three dedents
		script[14] = {12'h555,  1'b0, 1'b1, 1'b1, KIND_INDENT, 12'h555};
		script[15] = {12'hAAA,  1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};
		script[16] = {12'hFFF,  1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};
		script[17] = {12'h555,  1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};    // two dedents
		script[18] = {12'd0,    1'b1, 1'b1, 1'b0, KIND_INDENT, 12'd0};    // skipped, zero
		script[19] = {12'd0,    1'b0, 1'b0, 1'b0, KIND_INDENT, 12'd0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_line(script[i]);
		s_tvalid <= 1'b0;

		// Hold the sender until the tracker has delivered every outstanding token.
		while (pending_tokens.size() != 0) @(posedge clk);

		// Random well-formed nesting: pushes, equal lines, dedents onto open columns and
		// skipped lines. The stack never fills here, so the tracker stays out of error.
		for (int n = 0; n < RANDOM_LINES; n++) begin
			idle_en = !(n >= 24 && n < 32);
			if (n == 12) begin
				// Deep ramp to one below full, then unwind it in a single long dedent run.
				send_line(plain_row(12'd0, 1'b0));
				repeat (STACK_DEPTH - 2)
					send_line(plain_row(12'(top_col() + $urandom_range(1, 60)), 1'b0));
				send_line(plain_row(12'd0, 1'b0));
			end
			pick = $urandom_range(0, 99);
			skip = 1'b0;
			if (pick < 10) begin
				skip = 1'b1;
				col = 12'($urandom_range(0, COLUMN_MAX));
			end else if (pick < 20) begin
				col = top_col();
			end else if (pick < 25 && open_depth < STACK_DEPTH - 1 &&
					top_col() < COLUMN_MAX) begin
				col = 12'($urandom_range(top_col() + 1, COLUMN_MAX));
			end else if (pick < 55 && open_depth < STACK_DEPTH - 1 &&
					top_col() + 8 <= COLUMN_MAX) begin
				col = 12'(top_col() + $urandom_range(1, 8));
			end else begin
				idx = $urandom_range(0, open_depth - 1);
				col = open_cols[idx];
			end
			send_line(plain_row(col, skip));
		end

		// Last part: no idling on either side. One error per run, chosen at random, since
		// the tracker stays halted after it.
		idle_en = 1'b0;
		send_line(plain_row(12'd0, 1'b0));
		if ($urandom_range(0, 1) == 1) begin
			// Fill the stack completely, then go deeper once more.
			repeat (STACK_DEPTH - 1)
				send_line(plain_row(12'(top_col() + $urandom_range(1, 60)), 1'b0));
			send_line(plain_row(12'(COLUMN_MAX), 1'b0));
		end else begin
			// Open three columns and dedent to a column that falls between the first two.
			col = 12'($urandom_range(1, 30));
			send_line(plain_row(col, 1'b0));
			send_line(plain_row(12'(col + $urandom_range(2, 30)), 1'b0));
			send_line(plain_row(12'(top_col() + $urandom_range(1, 30)), 1'b0));
			send_line(plain_row(12'(col + 1), 1'b0));
		end

		// Halted tracker: every line, skipped or not, draws a single error token.
		repeat (10)
			send_line(plain_row(12'($urandom_range(0, COLUMN_MAX)),
				1'($urandom_range(0, 1))));
		s_tvalid <= 1'b0;

		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_tokens.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
